[sv/cte_pkg.sv]
// ----------------------------------------------------------------------------
// cte_pkg: shared types and constants for the calendar to epoch converter
// Holds the sequencer state type, the control bundle of the shared
// multiply-accumulate unit and the calendar tables.
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam int ACC_W     = 59;
    localparam int YEAR_W    = 14;
    localparam int DOY_W     = 9;
    localparam int FACTOR_W  = 10;
    localparam int STEP_W    = 3;
    localparam int MAC_STEPS = 5;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    // Days from year 1 to 1970-01-01, plus one for the one-based day of year.
    localparam logic [ACC_W-1:0] EPOCH_DAYS_PLUS_ONE = 59'd719163;
    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 10000.
    localparam logic [13:0] DIV100_MUL   = 14'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SPLIT = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_DAYS  = 6'b001000,
        ST_MAC   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                load;
        logic                step;
        logic [FACTOR_W-1:0] factor;
        logic [ACC_W-1:0]    value;
    } mac_ctrl_t;

    // Multiplier for each Horner step: hours, minutes, seconds, millis, micros.
    function automatic logic [FACTOR_W-1:0] step_factor(input logic [STEP_W-1:0] s);
        logic [FACTOR_W-1:0] f;
        case (s)
            3'd0:    f = 10'd24;
            3'd1:    f = 10'd60;
            3'd2:    f = 10'd60;
            default: f = 10'd1000;
        endcase
        return f;
    endfunction

    // Length of a month in a common year; zero for codes that are no month.
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Days before the first of a month in a common year.
    function automatic logic [DOY_W-1:0] days_before(input logic [3:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

[sv/cte_mac.sv]
// ----------------------------------------------------------------------------
// cte_mac: shared multiply-accumulate unit
// Holds the running total; a load sets it to a value, and each step replaces
// it by total * factor plus an addend, all modulo 2^59.
// ----------------------------------------------------------------------------
module cte_mac (
    input  logic                             aclk,
    input  cte_pkg::mac_ctrl_t               ctrl,
    output logic [cte_pkg::ACC_W-1:0]        acc
);
    import cte_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.load) begin
            acc_next = ctrl.value;
        end else if (ctrl.step) begin
            acc_next = acc_reg * ACC_W'(ctrl.factor) + ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[sv/calendar_to_epoch_micros.sv]
// ----------------------------------------------------------------------------
// calendar_to_epoch_micros: Gregorian date and time to epoch microseconds
// Checks the fields, counts days since 1970-01-01 and folds in the time of
// day through a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A valid date passes through the split, check and days states, the five
// steps of the shared multiply-accumulate unit and done; an invalid one goes
// from check to done. s_ready is high only while the sequencer idles, so a
// new transaction is taken only once the last result has left done.
// Reset clears the sequencer and the output valid and sets the zone offset
// to 8 hours.
module calendar_to_epoch_micros (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic signed [4:0]          cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [13:0]                s_year_in,
    input  logic [3:0]                 s_month_in,
    input  logic [4:0]                 s_day_in,
    input  logic [4:0]                 s_hour_in,
    input  logic [5:0]                 s_minute_in,
    input  logic [5:0]                 s_second_in,
    input  logic [9:0]                 s_milli_in,
    input  logic [9:0]                 s_micro_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [58:0]         m_epoch_micros,
    output logic                       m_fields_valid,
    output logic [8:0]                 m_day_of_year
);
    import cte_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [4:0]        zone_reg;

    logic [YEAR_W-1:0] year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg, hour_reg;
    logic [5:0]        minute_reg, second_reg;
    logic [9:0]        milli_reg, micro_reg;

    logic [7:0]        quot_reg;
    logic              ok_reg;
    logic [DOY_W-1:0]  doy_reg;

    logic              m_valid_reg;
    logic [ACC_W-1:0]  epoch_reg;
    logic              fvalid_reg;
    logic [DOY_W-1:0]  doy_out_reg;

    logic [YEAR_W-1:0] prev_year;
    logic [YEAR_W-1:0] div_in;
    logic [27:0]       div_prod;
    logic [7:0]        quot;
    logic [YEAR_W-1:0] rem100;
    logic              leap;
    logic [4:0]        mlen;
    logic              ok;
    logic [DOY_W-1:0]  doy;
    logic [ACC_W-1:0]  year_days;
    logic [ACC_W-1:0]  addend;
    logic              out_load;
    mac_ctrl_t         mac_ctrl;
    logic [ACC_W-1:0]  acc;

    assign prev_year = year_reg - 14'd1;

    // One constant divider by 100, used first on the year, then on year - 1.
    assign div_in   = (state_reg == ST_SPLIT) ? year_reg : prev_year;
    assign div_prod = 28'(div_in) * 28'(DIV100_MUL);
    assign quot     = div_prod[DIV100_SHIFT +: 8];

    always_comb begin
        rem100 = year_reg - YEAR_W'(quot_reg) * 14'd100;
        leap   = ((year_reg[1:0] == 2'd0) && (rem100 != '0)) ||
                 ((rem100 == '0) && (quot_reg[1:0] == 2'd0));
        mlen   = (month_reg == 4'd2 && leap) ? 5'd29 : month_length(month_reg);
        ok     = (year_reg <= YEAR_MAX) && (month_reg >= 4'd1) && (month_reg <= 4'd12) &&
                 (day_reg >= 5'd1) && (day_reg <= mlen) && (hour_reg <= 5'd23) &&
                 (minute_reg <= 6'd59) && (second_reg <= 6'd59) &&
                 (milli_reg <= 10'd999) && (micro_reg <= 10'd999);
        doy    = days_before(month_reg) + DOY_W'(leap && (month_reg > 4'd2)) +
                 DOY_W'(day_reg);
    end

    // Here quot_reg holds (year - 1) / 100; year zero counts no days.
    always_comb begin
        if (year_reg == '0) begin
            year_days = '0;
        end else begin
            year_days = ACC_W'(prev_year) * 59'd365 + ACC_W'(prev_year[YEAR_W-1:2]) -
                        ACC_W'(quot_reg) + ACC_W'(quot_reg[7:2]);
        end
    end

    always_comb begin
        case (step_reg)
            3'd0:    addend = ACC_W'(hour_reg) - {{(ACC_W-5){zone_reg[4]}}, zone_reg};
            3'd1:    addend = ACC_W'(minute_reg);
            3'd2:    addend = ACC_W'(second_reg);
            3'd3:    addend = ACC_W'(milli_reg);
            default: addend = ACC_W'(micro_reg);
        endcase
    end

    always_comb begin
        mac_ctrl.load   = (state_reg == ST_DAYS);
        mac_ctrl.step   = (state_reg == ST_MAC);
        mac_ctrl.factor = step_factor(step_reg);
        mac_ctrl.value  = (state_reg == ST_DAYS)
                        ? year_days + ACC_W'(doy_reg) - EPOCH_DAYS_PLUS_ONE
                        : addend;
    end

    cte_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .acc  (acc)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ok ? ST_DAYS : ST_DONE;
            end
            ST_DAYS: begin
                state_next = ST_MAC;
                step_next  = '0;
            end
            ST_MAC: begin
                if (step_reg == STEP_W'(MAC_STEPS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            zone_reg    <= 5'd8;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we) begin
                zone_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            year_reg   <= s_year_in;
            month_reg  <= s_month_in;
            day_reg    <= s_day_in;
            hour_reg   <= s_hour_in;
            minute_reg <= s_minute_in;
            second_reg <= s_second_in;
            milli_reg  <= s_milli_in;
            micro_reg  <= s_micro_in;
        end
        if (state_reg == ST_SPLIT || state_reg == ST_CHECK) begin
            quot_reg <= quot;
        end
        if (state_reg == ST_CHECK) begin
            ok_reg  <= ok;
            doy_reg <= doy;
        end
        if (out_load) begin
            epoch_reg   <= ok_reg ? acc : '0;
            fvalid_reg  <= ok_reg;
            doy_out_reg <= ok_reg ? doy_reg : '0;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_epoch_micros = epoch_reg;
    assign m_fields_valid = fvalid_reg;
    assign m_day_of_year  = doy_out_reg;

endmodule

[verif/calendar_to_epoch_micros_checker.sv]
// ----------------------------------------------------------------------------
// calendar_to_epoch_micros_checker: result predictor and scoreboard
// Tracks the zone offset register, predicts the epoch time, range flag and
// day of year for every accepted input transaction and compares each result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_to_epoch_micros_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic signed [4:0]   cfg_wdata,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [13:0]         s_year_in,
    input  logic [3:0]          s_month_in,
    input  logic [4:0]          s_day_in,
    input  logic [4:0]          s_hour_in,
    input  logic [5:0]          s_minute_in,
    input  logic [5:0]          s_second_in,
    input  logic [9:0]          s_milli_in,
    input  logic [9:0]          s_micro_in,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [58:0]  m_epoch_micros,
    input  logic                m_fields_valid,
    input  logic [8:0]          m_day_of_year,
    output int                  mismatch_count,
    output int                  pending_count
);

    localparam longint MICROS_PER_DAY  = 64'sd86400000000;
    localparam longint MICROS_PER_HOUR = 64'sd3600000000;
    localparam longint MICROS_PER_MIN  = 64'sd60000000;
    localparam longint MICROS_PER_SEC  = 64'sd1000000;
    localparam int     REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [58:0] micros;
        logic               in_range;
        logic [8:0]         doy;
    } epoch_result_t;

    epoch_result_t     expected_epochs[$];
    epoch_result_t     oldest;
    logic signed [4:0] zone_hours;
    int                fail_total;

    function automatic bit is_leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in_month(input longint y, input longint m);
        longint n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = is_leap_year(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // Days elapsed from 0001-01-01 to the first of year y; year zero maps to zero.
    function automatic longint days_before_year(input longint y);
        longint p;
        if (y < 1) return 0;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic epoch_result_t convert_to_epoch(
        input logic [13:0] year_f, input logic [3:0] month_f, input logic [4:0] day_f,
        input logic [4:0] hour_f, input logic [5:0] minute_f, input logic [5:0] second_f,
        input logic [9:0] milli_f, input logic [9:0] micro_f, input logic signed [4:0] zone
    );
        epoch_result_t r;
        longint        y, mo, d, h, mi, s, ms, us, z;
        longint        doy, days, total, m;
        bit            ok;
        r  = '0;
        y  = year_f;
        mo = month_f;
        d  = day_f;
        h  = hour_f;
        mi = minute_f;
        s  = second_f;
        ms = milli_f;
        us = micro_f;
        z  = zone;
        ok = (y <= 9999) && (mo >= 1) && (mo <= 12) && (d >= 1) &&
             (d <= days_in_month(y, mo)) && (h <= 23) && (mi <= 59) &&
             (s <= 59) && (ms <= 999) && (us <= 999);
        if (!ok) return r;
        doy = 0;
        for (m = 1; m < mo; m++) doy += days_in_month(y, m);
        doy += d;
        days  = days_before_year(y) - days_before_year(1970) + doy - 1;
        total = days * MICROS_PER_DAY + (h - z) * MICROS_PER_HOUR +
                mi * MICROS_PER_MIN + s * MICROS_PER_SEC + ms * 1000 + us;
        r.micros   = total[58:0];
        r.in_range = 1'b1;
        r.doy      = doy[8:0];
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) $display("%s", msg);
    endtask

    initial begin
        fail_total     = 0;
        mismatch_count = 0;
        pending_count  = 0;
        zone_hours     = 5'sd8;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            zone_hours <= 5'sd8;
            expected_epochs.delete();
        end else begin
            // The user must make register writes only while the block is idle; the
            // block does not enforce it, and a new transaction gets the old zone.
            if (cfg_we) zone_hours <= cfg_wdata;
            if (s_valid && s_ready) begin
                expected_epochs.push_back(convert_to_epoch(s_year_in, s_month_in,
                    s_day_in, s_hour_in, s_minute_in, s_second_in, s_milli_in,
                    s_micro_in, zone_hours));
            end
            if (m_valid && m_ready) begin
                if (expected_epochs.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result transaction: micros %0d valid %0b doy %0d",
                        m_epoch_micros, m_fields_valid, m_day_of_year));
                end else begin
                    oldest = expected_epochs.pop_front();
                    if (m_epoch_micros !== oldest.micros ||
                        m_fields_valid !== oldest.in_range ||
                        m_day_of_year !== oldest.doy) begin
                        note_mismatch($sformatf(
                            {"result mismatch: expected micros %0d valid %0b doy %0d,",
                             " got micros %0d valid %0b doy %0d"},
                            oldest.micros, oldest.in_range, oldest.doy,
                            m_epoch_micros, m_fields_valid, m_day_of_year));
                    end
                end
            end
        end
        mismatch_count <= fail_total;
        pending_count  <= expected_epochs.size();
    end

endmodule

[verif/calendar_to_epoch_micros_tb.sv]
// ----------------------------------------------------------------------------
// calendar_to_epoch_micros_tb: stimulus and verdict for the epoch converter
// Drives directed corner dates and then random valid, broken and raw field
// sets under several zone offsets, with random idle cycles on both channels
// and one long output stall. The checker module scores every result.
// ----------------------------------------------------------------------------
module calendar_to_epoch_micros_tb;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASE_COUNT     = 7;
    localparam int HOLD_PHASE      = 2;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic [cte_pkg::YEAR_W-1:0] year;
        logic [3:0]                 month;
        logic [4:0]                 day;
        logic [4:0]                 hour;
        logic [5:0]                 minute;
        logic [5:0]                 second;
        logic [9:0]                 milli;
        logic [9:0]                 micro;
    } cal_item_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic signed [4:0]           cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic [cte_pkg::YEAR_W-1:0]  s_year_in;
    logic [3:0]                  s_month_in;
    logic [4:0]                  s_day_in;
    logic [4:0]                  s_hour_in;
    logic [5:0]                  s_minute_in;
    logic [5:0]                  s_second_in;
    logic [9:0]                  s_milli_in;
    logic [9:0]                  s_micro_in;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [cte_pkg::ACC_W-1:0] m_epoch_micros;
    logic                        m_fields_valid;
    logic [cte_pkg::DOY_W-1:0]   m_day_of_year;

    int mismatch_count;
    int pending_count;
    int idle_cycles;
    bit tx_steady;
    bit rx_steady;
    bit rx_hold_req;

    calendar_to_epoch_micros u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_year_in      (s_year_in),
        .s_month_in     (s_month_in),
        .s_day_in       (s_day_in),
        .s_hour_in      (s_hour_in),
        .s_minute_in    (s_minute_in),
        .s_second_in    (s_second_in),
        .s_milli_in     (s_milli_in),
        .s_micro_in     (s_micro_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_epoch_micros (m_epoch_micros),
        .m_fields_valid (m_fields_valid),
        .m_day_of_year  (m_day_of_year)
    );

    calendar_to_epoch_micros_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_year_in      (s_year_in),
        .s_month_in     (s_month_in),
        .s_day_in       (s_day_in),
        .s_hour_in      (s_hour_in),
        .s_minute_in    (s_minute_in),
        .s_second_in    (s_second_in),
        .s_milli_in     (s_milli_in),
        .s_micro_in     (s_micro_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_epoch_micros (m_epoch_micros),
        .m_fields_valid (m_fields_valid),
        .m_day_of_year  (m_day_of_year),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cal_item_t make_item(input int y, input int mo, input int d,
                                            input int h, input int mi, input int s,
                                            input int ms, input int us);
        cal_item_t it;
        it.year   = cte_pkg::YEAR_W'(y);
        it.month  = 4'(mo);
        it.day    = 5'(d);
        it.hour   = 5'(h);
        it.minute = 6'(mi);
        it.second = 6'(s);
        it.milli  = 10'(ms);
        it.micro  = 10'(us);
        return it;
    endfunction

    // Mostly no idling, sometimes a few cycles, rarely a long gap.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A well-formed date except that days 29 to 31 may overrun short months.
    function automatic cal_item_t random_date();
        cal_item_t it;
        it = make_item($urandom_range(0, 9999), $urandom_range(1, 12),
                       $urandom_range(1, 28), $urandom_range(0, 23),
                       $urandom_range(0, 59), $urandom_range(0, 59),
                       $urandom_range(0, 999), $urandom_range(0, 999));
        if ($urandom_range(0, 6) == 0) begin
            case ($urandom_range(0, 9))
                0: it.year = 14'd0;
                1: it.year = 14'd1;
                2: it.year = 14'd4;
                3: it.year = 14'd100;
                4: it.year = 14'd400;
                5: it.year = 14'd1900;
                6: it.year = 14'd1970;
                7: it.year = 14'd2000;
                8: it.year = 14'd1969;
                default: it.year = 14'd9999;
            endcase
        end
        if ($urandom_range(0, 3) == 0) it.day = 5'($urandom_range(29, 31));
        return it;
    endfunction

    // A date with one field pushed outside its valid range; the day may also overrun a short month.
    function automatic cal_item_t broken_date();
        cal_item_t it;
        it = random_date();
        case ($urandom_range(0, 7))
            0: it.year   = cte_pkg::YEAR_W'($urandom_range(10000, 16383));
            1: it.month  = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            2: it.day    = 5'd0;
            3: it.hour   = 5'($urandom_range(24, 31));
            4: it.minute = 6'($urandom_range(60, 63));
            5: it.second = 6'($urandom_range(60, 63));
            6: it.milli  = 10'($urandom_range(1000, 1023));
            default: it.micro = 10'($urandom_range(1000, 1023));
        endcase
        return it;
    endfunction

    function automatic cal_item_t random_item();
        int          r;
        logic [63:0] raw;
        cal_item_t   it;
        r = $urandom_range(0, 99);
        if (r < 65) return random_date();
        if (r < 85) return broken_date();
        raw = {$urandom, $urandom};
        it  = raw[$bits(cal_item_t)-1:0];
        return it;
    endfunction

    function automatic logic signed [4:0] zone_for_phase(input int p);
        logic signed [4:0] z;
        case (p)
            0:       z = -5'sd16;
            1:       z = 5'sd15;
            2:       z = -5'sd12;
            3:       z = 5'sd14;
            4:       z = 5'sd0;
            default: z = 5'($urandom_range(0, 31));
        endcase
        return z;
    endfunction

    task automatic send_item(input cal_item_t it);
        int gap;
        gap = tx_steady ? 0 : idle_length();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_year_in   = it.year;
        s_month_in  = it.month;
        s_day_in    = it.day;
        s_hour_in   = it.hour;
        s_minute_in = it.minute;
        s_second_in = it.second;
        s_milli_in  = it.milli;
        s_micro_in  = it.micro;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_zone(input logic signed [4:0] z);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = z;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // Output side: random stalls, steady stretches, and one long hold-off.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES;
            end
            if (stall_left == 0 && !rx_steady) stall_left = idle_length();
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_year_in   = '0;
        s_month_in  = '0;
        s_day_in    = '0;
        s_hour_in   = '0;
        s_minute_in = '0;
        s_second_in = '0;
        s_milli_in  = '0;
        s_micro_in  = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed corners under the reset zone offset.
        send_item(make_item(1970, 1, 1, 0, 0, 0, 0, 0));
        send_item(make_item(1970, 1, 1, 8, 0, 0, 0, 0));
        send_item(make_item(0, 1, 1, 0, 0, 0, 0, 0));
        send_item(make_item(1, 1, 1, 0, 0, 0, 0, 0));
        send_item(make_item(0, 2, 29, 12, 30, 30, 500, 500));
        send_item(make_item(9999, 12, 31, 23, 59, 59, 999, 999));
        send_item(make_item(2000, 2, 29, 1, 2, 3, 4, 5));
        send_item(make_item(1900, 2, 29, 0, 0, 0, 0, 0));
        send_item(make_item(2024, 2, 29, 0, 0, 0, 0, 0));
        send_item(make_item(2023, 2, 29, 0, 0, 0, 0, 0));
        send_item(make_item(2024, 12, 31, 23, 0, 0, 0, 0));
        send_item(make_item(1969, 12, 31, 23, 59, 59, 999, 999));
        send_item(make_item(10000, 1, 1, 0, 0, 0, 0, 0));
        send_item(make_item(16383, 6, 15, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 0, 1, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 13, 1, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 15, 1, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 5, 0, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 4, 31, 0, 0, 0, 0, 0));
        send_item(make_item(2020, 5, 31, 31, 0, 0, 0, 0));
        send_item(make_item(2020, 5, 1, 24, 63, 0, 0, 0));
        send_item(make_item(2020, 5, 1, 0, 60, 0, 0, 0));
        send_item(make_item(2020, 5, 1, 0, 0, 60, 0, 0));
        send_item(make_item(2020, 5, 1, 0, 0, 0, 1000, 0));
        send_item(make_item(16383, 15, 31, 31, 63, 63, 1023, 1023));
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_zone(zone_for_phase(p));
            tx_steady = (p == 1);
            rx_steady = (p == 1) || (p == 4);
            if (p == HOLD_PHASE) begin
                @(posedge aclk);
                rx_hold_req = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(random_item());
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
